### sv/sds_pkg.sv
// Shared types, codes and helper functions for the staged deploy sequencer.
package sds_pkg;

    // Sequencer modes, as reported on the fsm_state output
    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_ARMED    = 3'd1,
        MODE_S1       = 3'd2,
        MODE_S2       = 3'd3,
        MODE_S3       = 3'd4,
        MODE_DEPLOYED = 3'd5,
        MODE_MANUAL   = 3'd6
    } t_mode;

    // Input opcodes; code seven is unused and leaves the state alone
    typedef enum logic [2:0] {
        OP_TICK         = 3'd0,
        OP_ARM          = 3'd1,
        OP_DISARM       = 3'd2,
        OP_ENTER_MANUAL = 3'd3,
        OP_EXIT_MANUAL  = 3'd4,
        OP_FORCE_OPEN   = 3'd5,
        OP_FORCE_CLOSE  = 3'd6
    } t_op;

    // Actuator drive codes
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_OPEN  = 2'd1,
        ACT_CLOSE = 2'd2
    } t_act;

    // Configuration register indexes
    localparam logic [1:0] CFG_STAGE1_ETA    = 2'd0;
    localparam logic [1:0] CFG_STAGE2_ETA    = 2'd1;
    localparam logic [1:0] CFG_STAGE3_ETA    = 2'd2;
    localparam logic [1:0] CFG_FINAL_TIMEOUT = 2'd3;

    // Configuration reset values (ms)
    localparam logic [15:0] STAGE1_ETA_RST    = 16'd3000;
    localparam logic [15:0] STAGE2_ETA_RST    = 16'd2000;
    localparam logic [15:0] STAGE3_ETA_RST    = 16'd1000;
    localparam logic [15:0] FINAL_TIMEOUT_RST = 16'd3000;

    typedef struct packed {
        logic [15:0] stage1_eta_ms;
        logic [15:0] stage2_eta_ms;
        logic [15:0] stage3_eta_ms;
        logic [15:0] final_timeout_ms;
    } t_cfg;

    // One input beat
    typedef struct packed {
        logic [2:0]         op;
        logic [31:0]        now_ms;
        logic signed [31:0] apogee_eta_ms;
        logic signed [23:0] climb_rate_mm_s;
        logic [1:0]         batch_sel;
    } t_item;

    // Sequencer state carried from beat to beat
    typedef struct packed {
        t_mode       mode;
        logic        entry_done;
        logic [1:0]  stage_count;
        logic [2:0]  open_bits;
        logic [31:0] entry_time;
    } t_state;

    // One result beat
    typedef struct packed {
        t_mode      fsm_state;
        logic [1:0] deployed_count;
        logic [2:0] open_mask;
        t_act       actuate;
        logic [1:0] actuate_batch;
        logic       rejected;
    } t_result;

    // True when 0 < eta <= thr, eta signed, thr unsigned 16 bit
    function automatic logic in_window(logic [31:0] eta, logic [15:0] thr);
        return !eta[31] && (eta != 32'd0) && (eta[31:16] == 16'd0) &&
               (eta[15:0] <= thr);
    endfunction

    // One-hot bit for batch one to three; batch zero gives no bit
    function automatic logic [2:0] batch_bit(logic [1:0] batch);
        logic [2:0] bits;
        case (batch)
            2'd1:    bits = 3'b001;
            2'd2:    bits = 3'b010;
            2'd3:    bits = 3'b100;
            default: bits = 3'b000;
        endcase
        return bits;
    endfunction

endpackage

### sv/staged_deploy_sequencer.sv
// A beat is captured in the input register and moves on to the result register once that has room.
// Throughput: one beat per cycle while results drain; with a result waiting, one more
// beat is held in the input register and then the input stalls until the result goes.
// The per-beat work is one pass of compare/subtract logic between the two registers.
// Reset (synchronous, active low) empties both registers, puts the sequencer in idle
// with all batches closed and loads the default thresholds and timeout.
module staged_deploy_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_op,
    input  logic [31:0]        i_now_ms,
    input  logic signed [31:0] i_apogee_eta_ms,
    input  logic signed [23:0] i_climb_rate_mm_s,
    input  logic [1:0]         i_batch_sel,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_fsm_state,
    output logic [1:0]         o_deployed_count,
    output logic [2:0]         o_open_mask,
    output logic [1:0]         o_actuate,
    output logic [1:0]         o_actuate_batch,
    output logic               o_rejected,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_wdata
);

    sds_pkg::t_cfg    cfg;
    sds_pkg::t_item   r_in;
    logic             r_in_valid;
    sds_pkg::t_state  r_state;
    sds_pkg::t_state  n_state;
    sds_pkg::t_result r_out;
    sds_pkg::t_result n_out;
    logic             r_out_valid;
    logic             advance;

    // Configuration registers
    sds_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Move the held beat into the result register when it has room
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.op              <= i_op;
            r_in.now_ms          <= i_now_ms;
            r_in.apogee_eta_ms   <= i_apogee_eta_ms;
            r_in.climb_rate_mm_s <= i_climb_rate_mm_s;
            r_in.batch_sel       <= i_batch_sel;
        end
    end

    // Sequencer step
    sds_step u_step (
        .i_state  (r_state),
        .i_cfg    (cfg),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Hold the sequencer state; update it as each beat passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode        <= sds_pkg::MODE_IDLE;
            r_state.entry_done  <= 1'b0;
            r_state.stage_count <= 2'd0;
            r_state.open_bits   <= 3'd0;
            r_state.entry_time  <= 32'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_fsm_state      = 3'(r_out.fsm_state);
    assign o_deployed_count = r_out.deployed_count;
    assign o_open_mask      = r_out.open_mask;
    assign o_actuate        = 2'(r_out.actuate);
    assign o_actuate_batch  = r_out.actuate_batch;
    assign o_rejected       = r_out.rejected;

    // Idle always means no stage counted and every batch closed
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == sds_pkg::MODE_IDLE) |->
            (r_state.stage_count == 2'd0 && r_state.open_bits == 3'd0))
        else $error("idle mode with stage count or open batches");

    // A rejected force drives nothing
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |->
            (o_actuate == 2'(sds_pkg::ACT_NONE) && o_actuate_batch == 2'd0))
        else $error("rejected beat drives the actuator");

    // An open drive always leaves its batch open
    a_open_sets_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_actuate == 2'(sds_pkg::ACT_OPEN)) |->
            ((o_open_mask & sds_pkg::batch_bit(o_actuate_batch)) != 3'd0))
        else $error("open drive without open batch bit");

    // A result appears only after a beat went through the sequencer
    a_out_from_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without an input beat");

endmodule

### sv/sds_cfg_regs.sv
// Configuration register file: thresholds and final timeout.
module sds_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_wdata,
    output sds_pkg::t_cfg       o_cfg
);

    sds_pkg::t_cfg r_cfg;
    sds_pkg::t_cfg n_cfg;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                sds_pkg::CFG_STAGE1_ETA:    n_cfg.stage1_eta_ms    = i_cfg_wdata;
                sds_pkg::CFG_STAGE2_ETA:    n_cfg.stage2_eta_ms    = i_cfg_wdata;
                sds_pkg::CFG_STAGE3_ETA:    n_cfg.stage3_eta_ms    = i_cfg_wdata;
                sds_pkg::CFG_FINAL_TIMEOUT: n_cfg.final_timeout_ms = i_cfg_wdata;
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    // Hold the registers; reset loads the defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stage1_eta_ms    <= sds_pkg::STAGE1_ETA_RST;
            r_cfg.stage2_eta_ms    <= sds_pkg::STAGE2_ETA_RST;
            r_cfg.stage3_eta_ms    <= sds_pkg::STAGE3_ETA_RST;
            r_cfg.final_timeout_ms <= sds_pkg::FINAL_TIMEOUT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/sds_step.sv
// Next-state and result logic for one beat of the deploy sequencer.
module sds_step (
    input  sds_pkg::t_state  i_state,
    input  sds_pkg::t_cfg    i_cfg,
    input  sds_pkg::t_item   i_item,
    output sds_pkg::t_state  o_state,
    output sds_pkg::t_result o_result
);

    sds_pkg::t_state n_st;
    sds_pkg::t_act   act;
    logic [1:0]      act_batch;
    logic            rej;
    logic            climb_le0;
    logic [1:0]      stage_batch;
    logic [31:0]     elapsed;
    logic            force_ok;

    // Climb rate zero or negative
    assign climb_le0 = (i_item.climb_rate_mm_s == 24'sd0) || i_item.climb_rate_mm_s[23];

    // Batch opened by the current stage's entry action
    always_comb begin
        case (i_state.mode)
            sds_pkg::MODE_S1: stage_batch = 2'd1;
            sds_pkg::MODE_S2: stage_batch = 2'd2;
            sds_pkg::MODE_S3: stage_batch = 2'd3;
            default:          stage_batch = 2'd0;
        endcase
    end

    assign force_ok = (i_state.mode == sds_pkg::MODE_MANUAL) && (i_item.batch_sel != 2'd0);

    always_comb begin
        n_st      = i_state;
        act       = sds_pkg::ACT_NONE;
        act_batch = 2'd0;
        rej       = 1'b0;
        elapsed   = 32'd0;
        case (sds_pkg::t_op'(i_item.op))
            sds_pkg::OP_TICK: begin
                // Run the entry bookkeeping first
                if (!i_state.entry_done) begin
                    n_st.entry_done = 1'b1;
                    n_st.entry_time = i_item.now_ms;
                    if (i_state.mode == sds_pkg::MODE_IDLE) begin
                        n_st.stage_count = 2'd0;
                    end
                    if (stage_batch != 2'd0) begin
                        n_st.stage_count = stage_batch;
                        n_st.open_bits   = i_state.open_bits | sds_pkg::batch_bit(stage_batch);
                        act              = sds_pkg::ACT_OPEN;
                        act_batch        = stage_batch;
                    end
                end
                // Then advance the mode
                case (i_state.mode)
                    sds_pkg::MODE_IDLE, sds_pkg::MODE_DEPLOYED, sds_pkg::MODE_MANUAL: begin
                    end
                    sds_pkg::MODE_ARMED: begin
                        if (sds_pkg::in_window(i_item.apogee_eta_ms, i_cfg.stage1_eta_ms)) begin
                            n_st.mode       = sds_pkg::MODE_S1;
                            n_st.entry_done = 1'b0;
                        end
                    end
                    sds_pkg::MODE_S1: begin
                        if (sds_pkg::in_window(i_item.apogee_eta_ms, i_cfg.stage2_eta_ms)) begin
                            n_st.mode       = sds_pkg::MODE_S2;
                            n_st.entry_done = 1'b0;
                        end
                    end
                    sds_pkg::MODE_S2: begin
                        if (sds_pkg::in_window(i_item.apogee_eta_ms, i_cfg.stage3_eta_ms)) begin
                            n_st.mode       = sds_pkg::MODE_S3;
                            n_st.entry_done = 1'b0;
                        end
                    end
                    sds_pkg::MODE_S3: begin
                        // Elapsed time since stage three entry, against the updated entry time
                        elapsed = i_item.now_ms - n_st.entry_time;
                        if (climb_le0 || (elapsed >= {16'd0, i_cfg.final_timeout_ms})) begin
                            n_st.mode       = sds_pkg::MODE_DEPLOYED;
                            n_st.entry_done = 1'b0;
                        end
                    end
                    default: begin
                        // Unknown mode: drop back to idle
                        n_st            = i_state;
                        n_st.mode       = sds_pkg::MODE_IDLE;
                        n_st.entry_done = 1'b0;
                        n_st.stage_count = 2'd0;
                        n_st.open_bits  = 3'd0;
                        act             = sds_pkg::ACT_NONE;
                        act_batch       = 2'd0;
                    end
                endcase
            end
            sds_pkg::OP_ARM: begin
                n_st.mode       = sds_pkg::MODE_ARMED;
                n_st.entry_done = 1'b0;
            end
            sds_pkg::OP_ENTER_MANUAL: begin
                n_st.mode       = sds_pkg::MODE_MANUAL;
                n_st.entry_done = 1'b0;
            end
            sds_pkg::OP_DISARM, sds_pkg::OP_EXIT_MANUAL: begin
                n_st.mode        = sds_pkg::MODE_IDLE;
                n_st.entry_done  = 1'b0;
                n_st.stage_count = 2'd0;
                n_st.open_bits   = 3'd0;
            end
            sds_pkg::OP_FORCE_OPEN: begin
                if (force_ok) begin
                    n_st.open_bits = i_state.open_bits | sds_pkg::batch_bit(i_item.batch_sel);
                    act            = sds_pkg::ACT_OPEN;
                    act_batch      = i_item.batch_sel;
                end else begin
                    rej = 1'b1;
                end
            end
            sds_pkg::OP_FORCE_CLOSE: begin
                if (force_ok) begin
                    n_st.open_bits = i_state.open_bits & ~sds_pkg::batch_bit(i_item.batch_sel);
                    act            = sds_pkg::ACT_CLOSE;
                    act_batch      = i_item.batch_sel;
                end else begin
                    rej = 1'b1;
                end
            end
            default: begin
                // Unused opcode: hold the state, report it with no drive
            end
        endcase
    end

    assign o_state                 = n_st;
    assign o_result.fsm_state      = n_st.mode;
    assign o_result.deployed_count = n_st.stage_count;
    assign o_result.open_mask      = n_st.open_bits;
    assign o_result.actuate        = act;
    assign o_result.actuate_batch  = act_batch;
    assign o_result.rejected       = rej;

endmodule

### dv/tb.sv
// Self-checking testbench for the staged deploy sequencer: directed table, then random flights.
module tb;
    import sds_pkg::*;

    localparam logic [2:0] OP_UNUSED   = 3'd7;
    localparam int         CYCLE_LIMIT = 200000;

    // Directed stimulus row: beat plus an optional hand-written result
    typedef struct {
        t_item   beat;
        bit      has_fixed;
        t_result fixed;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_op;
    logic [31:0]        i_now_ms;
    logic signed [31:0] i_apogee_eta_ms;
    logic signed [23:0] i_climb_rate_mm_s;
    logic [1:0]         i_batch_sel;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [2:0]         o_fsm_state;
    logic [1:0]         o_deployed_count;
    logic [2:0]         o_open_mask;
    logic [1:0]         o_actuate;
    logic [1:0]         o_actuate_batch;
    logic               o_rejected;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_wdata;

    // Sequencer state as the predictor sees it
    t_mode       seq_mode;
    logic        seq_entry_done;
    logic [1:0]  seq_stage_count;
    logic [2:0]  seq_open;
    logic [31:0] seq_entry_time;
    logic [15:0] cfg_regs [4];

    t_result     pending_results [$];
    bit          beat_has_fixed;
    t_result     beat_fixed_res;
    bit          quiet_run;
    int          mismatches;
    int          beats_taken;
    int          effect_beats;
    int          results_checked;
    int          settings_used;
    int          cycle_count;

    staged_deploy_sequencer u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_now_ms          (i_now_ms),
        .i_apogee_eta_ms   (i_apogee_eta_ms),
        .i_climb_rate_mm_s (i_climb_rate_mm_s),
        .i_batch_sel       (i_batch_sel),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_fsm_state       (o_fsm_state),
        .o_deployed_count  (o_deployed_count),
        .o_open_mask       (o_open_mask),
        .o_actuate         (o_actuate),
        .o_actuate_batch   (o_actuate_batch),
        .o_rejected        (o_rejected),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_item make_beat(logic [2:0] op, logic [31:0] now, logic [31:0] eta,
                                        logic [23:0] climb, logic [1:0] bsel);
        t_item b;
        b.op              = op;
        b.now_ms          = now;
        b.apogee_eta_ms   = eta;
        b.climb_rate_mm_s = climb;
        b.batch_sel       = bsel;
        return b;
    endfunction

    function automatic t_result make_result(t_mode m, logic [1:0] cnt, logic [2:0] mask,
                                            t_act a, logic [1:0] ab, logic rej);
        t_result r;
        r.fsm_state      = m;
        r.deployed_count = cnt;
        r.open_mask      = mask;
        r.actuate        = a;
        r.actuate_batch  = ab;
        r.rejected       = rej;
        return r;
    endfunction

    function automatic t_item noise_beat();
        return make_beat(3'($urandom_range(0, 7)), $urandom, $urandom, 24'($urandom),
                         2'($urandom_range(0, 3)));
    endfunction

    // ---------------------------------------------------------------- predictor

    function automatic logic eta_in_range(logic signed [31:0] eta, logic [15:0] limit);
        return (eta > 0) && (eta <= $signed({16'h0000, limit}));
    endfunction

    function automatic void drop_to_idle();
        seq_mode        = MODE_IDLE;
        seq_entry_done  = 1'b0;
        seq_stage_count = 2'd0;
        seq_open        = 3'b000;
    endfunction

    // First tick in a stage: stamp the time, count the batch and open it
    function automatic void open_stage(logic [31:0] now, logic [1:0] batch, inout t_result r);
        if (!seq_entry_done) begin
            seq_entry_done  = 1'b1;
            seq_entry_time  = now;
            seq_stage_count = batch;
            seq_open        = seq_open | (3'b001 << (batch - 2'd1));
            r.actuate       = ACT_OPEN;
            r.actuate_batch = batch;
        end
    endfunction

    function automatic void sequencer_tick(t_item it, inout t_result r);
        logic [31:0] elapsed;
        case (seq_mode)
            MODE_IDLE: begin
                if (!seq_entry_done) begin
                    seq_entry_done  = 1'b1;
                    seq_stage_count = 2'd0;
                    seq_entry_time  = it.now_ms;
                end
            end
            MODE_ARMED: begin
                if (!seq_entry_done) begin
                    seq_entry_done = 1'b1;
                    seq_entry_time = it.now_ms;
                end
                if (eta_in_range(it.apogee_eta_ms, cfg_regs[CFG_STAGE1_ETA])) begin
                    seq_mode       = MODE_S1;
                    seq_entry_done = 1'b0;
                end
            end
            MODE_S1: begin
                open_stage(it.now_ms, 2'd1, r);
                if (eta_in_range(it.apogee_eta_ms, cfg_regs[CFG_STAGE2_ETA])) begin
                    seq_mode       = MODE_S2;
                    seq_entry_done = 1'b0;
                end
            end
            MODE_S2: begin
                open_stage(it.now_ms, 2'd2, r);
                if (eta_in_range(it.apogee_eta_ms, cfg_regs[CFG_STAGE3_ETA])) begin
                    seq_mode       = MODE_S3;
                    seq_entry_done = 1'b0;
                end
            end
            MODE_S3: begin
                open_stage(it.now_ms, 2'd3, r);
                // Elapsed time taken modulo 2^32 so a wrapping clock still times out
                elapsed = it.now_ms - seq_entry_time;
                if ($signed(it.climb_rate_mm_s) <= 0 ||
                    elapsed >= {16'h0000, cfg_regs[CFG_FINAL_TIMEOUT]}) begin
                    seq_mode       = MODE_DEPLOYED;
                    seq_entry_done = 1'b0;
                end
            end
            MODE_DEPLOYED, MODE_MANUAL: begin
                if (!seq_entry_done) begin
                    seq_entry_done = 1'b1;
                    seq_entry_time = it.now_ms;
                end
            end
            default: drop_to_idle();
        endcase
    endfunction

    function automatic t_result advance_sequencer(t_item it);
        t_result r;
        r = '0;
        case (it.op)
            OP_TICK: sequencer_tick(it, r);
            OP_ARM: begin
                seq_mode       = MODE_ARMED;
                seq_entry_done = 1'b0;
            end
            OP_DISARM, OP_EXIT_MANUAL: drop_to_idle();
            OP_ENTER_MANUAL: begin
                seq_mode       = MODE_MANUAL;
                seq_entry_done = 1'b0;
            end
            OP_FORCE_OPEN, OP_FORCE_CLOSE: begin
                if (seq_mode != MODE_MANUAL || it.batch_sel == 2'd0) begin
                    r.rejected = 1'b1;
                end else if (it.op == OP_FORCE_OPEN) begin
                    seq_open        = seq_open | (3'b001 << (it.batch_sel - 2'd1));
                    r.actuate       = ACT_OPEN;
                    r.actuate_batch = it.batch_sel;
                end else begin
                    seq_open        = seq_open & ~(3'b001 << (it.batch_sel - 2'd1));
                    r.actuate       = ACT_CLOSE;
                    r.actuate_batch = it.batch_sel;
                end
            end
            default: ;
        endcase
        r.fsm_state      = seq_mode;
        r.deployed_count = seq_stage_count;
        r.open_mask      = seq_open;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(string fld, int unsigned got, int unsigned want);
        mismatches++;
        $display("mismatch in %s at result %0d: got %0d, want %0d",
                 fld, results_checked, got, want);
    endtask

    // Predict on every accepted input beat, compare every accepted result beat
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_item   taken;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_fsm_state !== want.fsm_state)
                        flag_mismatch("fsm_state", o_fsm_state, want.fsm_state);
                    if (o_deployed_count !== want.deployed_count)
                        flag_mismatch("deployed_count", o_deployed_count, want.deployed_count);
                    if (o_open_mask !== want.open_mask)
                        flag_mismatch("open_mask", o_open_mask, want.open_mask);
                    if (o_actuate !== want.actuate)
                        flag_mismatch("actuate", o_actuate, want.actuate);
                    if (o_actuate_batch !== want.actuate_batch)
                        flag_mismatch("actuate_batch", o_actuate_batch, want.actuate_batch);
                    if (o_rejected !== want.rejected)
                        flag_mismatch("rejected", o_rejected, want.rejected);
                end
                results_checked++;
            end
            if (i_in_valid && o_in_ready) begin
                taken = make_beat(i_op, i_now_ms, i_apogee_eta_ms, i_climb_rate_mm_s,
                                  i_batch_sel);
                want  = advance_sequencer(taken);
                if (!want.rejected && taken.op != OP_UNUSED)
                    effect_beats++;
                if (beat_has_fixed)
                    want = beat_fixed_res;
                pending_results.push_back(want);
                beats_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // Result side: stall about a third of the cycles unless the run is quiet
    always @(negedge i_clk)
        i_out_ready <= quiet_run || ($urandom_range(0, 99) >= 33);

    // ---------------------------------------------------------------- stimulus

    // Present one beat at the falling edge and hold it until it is taken
    task automatic send_beat(t_item b, bit fixed = 1'b0, t_result fres = '0);
        if (!quiet_run && $urandom_range(0, 99) < 33) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_op              = b.op;
        i_now_ms          = b.now_ms;
        i_apogee_eta_ms   = b.apogee_eta_ms;
        i_climb_rate_mm_s = b.climb_rate_mm_s;
        i_batch_sel       = b.batch_sel;
        beat_has_fixed    = fixed;
        beat_fixed_res    = fres;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drain every pending result before touching the registers
    task automatic settle();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_setting(logic [1:0] idx, logic [15:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we      = 1'b0;
        cfg_regs[idx] = val;
    endtask

    function automatic logic [15:0] next_limit();
        case (seq_mode)
            MODE_ARMED: return cfg_regs[CFG_STAGE1_ETA];
            MODE_S1:    return cfg_regs[CFG_STAGE2_ETA];
            default:    return cfg_regs[CFG_STAGE3_ETA];
        endcase
    endfunction

    // Arm, then tick with a falling apogee estimate until deployed or given up
    task automatic run_flight();
        longint             eta;
        logic [31:0]        clock_ms;
        logic [15:0]        lim;
        logic signed [23:0] climb;
        int                 steps;
        int                 pick;
        int unsigned        time_step;
        bit                 down;
        send_beat(make_beat(OP_ARM, $urandom, $urandom, 24'($urandom),
                            2'($urandom_range(0, 3))));
        eta = longint'(cfg_regs[CFG_STAGE1_ETA]) + $urandom_range(0, 1500);
        case ($urandom_range(0, 2))
            0:       clock_ms = $urandom;
            1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            default: clock_ms = $urandom_range(0, 100000);
        endcase
        time_step = cfg_regs[CFG_FINAL_TIMEOUT] / 5 + 200;
        steps = 0;
        while (seq_mode != MODE_DEPLOYED && steps < 60) begin
            down  = $urandom_range(0, 99) < ((seq_mode == MODE_S3) ? 20 : 4);
            climb = down ? 24'(-int'($urandom_range(0, 8388608)))
                         : 24'($urandom_range(1, 8388607));
            // Stray commands mid-flight; all but the odd one are ignored
            pick = $urandom_range(0, 99);
            if (pick < 5)
                send_beat(make_beat(3'($urandom_range(5, 7)), $urandom, $urandom,
                                    24'($urandom), 2'($urandom_range(0, 3))));
            else if (pick < 6)
                send_beat(noise_beat());
            else
                send_beat(make_beat(OP_TICK, clock_ms, 32'(eta), climb,
                                    2'($urandom_range(0, 3))));
            // Move the estimate: hit window edges, recover noisy dips, or descend
            lim  = next_limit();
            pick = $urandom_range(0, 99);
            if (pick < 8)
                eta = lim;
            else if (pick < 12)
                eta = longint'(lim) + 1;
            else if (eta <= 0 && lim != 0 && pick < 70 &&
                     (seq_mode == MODE_ARMED || seq_mode == MODE_S1 || seq_mode == MODE_S2))
                eta = lim - $urandom_range(0, lim / 2);
            else
                eta = eta - $urandom_range(0, lim / 3 + 20);
            clock_ms = clock_ms + $urandom_range(0, time_step);
            steps++;
        end
        repeat ($urandom_range(0, 2))
            send_beat(make_beat(OP_TICK, clock_ms, $urandom, 24'($urandom),
                                2'($urandom_range(0, 3))));
        case ($urandom_range(0, 3))
            0, 1:    send_beat(make_beat(OP_DISARM, $urandom, $urandom, 24'($urandom), 2'd0));
            2:       send_beat(make_beat(OP_ENTER_MANUAL, $urandom, $urandom, 24'($urandom),
                                         2'd0));
            default: ;
        endcase
    endtask

    // Manual mode with forced opens and closes of random batches
    task automatic run_manual();
        send_beat(make_beat(OP_ENTER_MANUAL, $urandom, $urandom, 24'($urandom),
                            2'($urandom_range(0, 3))));
        repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 9) == 0)
                send_beat(make_beat(OP_TICK, $urandom, $urandom, 24'($urandom),
                                    2'($urandom_range(0, 3))));
            else
                send_beat(make_beat($urandom_range(0, 1) ? OP_FORCE_OPEN : OP_FORCE_CLOSE,
                                    $urandom, $urandom, 24'($urandom),
                                    2'($urandom_range(0, 3))));
        end
        case ($urandom_range(0, 3))
            0, 1:    send_beat(make_beat(OP_EXIT_MANUAL, $urandom, $urandom, 24'($urandom),
                                         2'd0));
            2:       send_beat(make_beat(OP_ARM, $urandom, $urandom, 24'($urandom), 2'd0));
            default: send_beat(make_beat(OP_DISARM, $urandom, $urandom, 24'($urandom), 2'd0));
        endcase
    endtask

    task automatic run_phase(logic [15:0] s1, logic [15:0] s2, logic [15:0] s3,
                             logic [15:0] tmo, int beats, bit quiet);
        int target;
        int pick;
        settle();
        write_setting(CFG_STAGE1_ETA, s1);
        write_setting(CFG_STAGE2_ETA, s2);
        write_setting(CFG_STAGE3_ETA, s3);
        write_setting(CFG_FINAL_TIMEOUT, tmo);
        settings_used++;
        quiet_run = quiet;
        target    = effect_beats + beats;
        while (effect_beats < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                run_flight();
            else if (pick < 82)
                run_manual();
            else
                repeat ($urandom_range(1, 5)) send_beat(noise_beat());
        end
    endtask

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    initial begin
        t_dir_row    script [$];
        logic [15:0] s3;
        logic [15:0] s2;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_op              = OP_TICK;
        i_now_ms          = '0;
        i_apogee_eta_ms   = '0;
        i_climb_rate_mm_s = '0;
        i_batch_sel       = '0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_STAGE1_ETA;
        i_cfg_wdata       = '0;
        quiet_run         = 1'b0;
        beat_has_fixed    = 1'b0;
        beat_fixed_res    = '0;
        seq_entry_time    = '0;
        drop_to_idle();
        cfg_regs[CFG_STAGE1_ETA]    = STAGE1_ETA_RST;
        cfg_regs[CFG_STAGE2_ETA]    = STAGE2_ETA_RST;
        cfg_regs[CFG_STAGE3_ETA]    = STAGE3_ETA_RST;
        cfg_regs[CFG_FINAL_TIMEOUT] = FINAL_TIMEOUT_RST;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed flight at reset thresholds: 3000 / 2000 / 1000 ms, timeout 3000 ms
        script.push_back('{make_beat(OP_TICK, 32'd0, 32'd0, 24'd0, 2'd0), 1'b1,
                           make_result(MODE_IDLE, 2'd0, 3'b000, ACT_NONE, 2'd0, 1'b0)});
        script.push_back('{make_beat(OP_FORCE_OPEN, 32'd0, 32'd0, 24'd0, 2'd1), 1'b1,
                           make_result(MODE_IDLE, 2'd0, 3'b000, ACT_NONE, 2'd0, 1'b1)});
        script.push_back('{make_beat(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF,
                                     2'd3), 1'b1,
                           make_result(MODE_IDLE, 2'd0, 3'b000, ACT_NONE, 2'd0, 1'b0)});
        script.push_back('{make_beat(OP_ARM, 32'd0, 32'd0, 24'd0, 2'd0), 1'b1,
                           make_result(MODE_ARMED, 2'd0, 3'b000, ACT_NONE, 2'd0, 1'b0)});
        script.push_back('{make_beat(OP_TICK, 32'd10, 32'h8000_0000, 24'h80_0000, 2'd0),
                           1'b0, '0});
        script.push_back('{make_beat(OP_TICK, 32'd20, 32'd3001, 24'd5000, 2'd0), 1'b0, '0});
        script.push_back('{make_beat(OP_TICK, 32'd100, 32'd3000, 24'd5000, 2'd0), 1'b0, '0});
        script.push_back('{make_beat(OP_TICK, 32'd200, 32'd2001, 24'd5000, 2'd0), 1'b0, '0});
        script.push_back('{make_beat(OP_TICK, 32'd300, 32'd2000, 24'd5000, 2'd0), 1'b0, '0});
        // Stage two entry chains straight into stage three
        script.push_back('{make_beat(OP_TICK, 32'd400, 32'd1000, 24'd5000, 2'd0), 1'b0, '0});
        // Stage three entered just before the clock wraps
        script.push_back('{make_beat(OP_TICK, 32'hFFFF_FFFF, 32'd500, 24'd1, 2'd0),
                           1'b0, '0});
        script.push_back('{make_beat(OP_TICK, 32'd2998, 32'd0, 24'h7F_FFFF, 2'd0), 1'b0, '0});
        script.push_back('{make_beat(OP_TICK, 32'd2999, 32'd0, 24'h7F_FFFF, 2'd0), 1'b0, '0});
        script.push_back('{make_beat(OP_TICK, 32'd5000, 32'd0, 24'd100, 2'd0), 1'b0, '0});
        script.push_back('{make_beat(OP_FORCE_CLOSE, 32'd0, 32'd0, 24'd0, 2'd2), 1'b0, '0});
        script.push_back('{make_beat(OP_ENTER_MANUAL, 32'd0, 32'd0, 24'd0, 2'd0), 1'b0, '0});
        script.push_back('{make_beat(OP_FORCE_CLOSE, 32'd0, 32'd0, 24'd0, 2'd0), 1'b0, '0});
        script.push_back('{make_beat(OP_FORCE_CLOSE, 32'd0, 32'd0, 24'd0, 2'd2), 1'b0, '0});
        // Forcing an already open batch still drives the actuator
        script.push_back('{make_beat(OP_FORCE_OPEN, 32'd0, 32'd0, 24'd0, 2'd3), 1'b0, '0});
        script.push_back('{make_beat(OP_TICK, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 24'h80_0000,
                                     2'd3), 1'b0, '0});
        script.push_back('{make_beat(OP_EXIT_MANUAL, 32'd0, 32'd0, 24'd0, 2'd0), 1'b1,
                           make_result(MODE_IDLE, 2'd0, 3'b000, ACT_NONE, 2'd0, 1'b0)});
        script.push_back('{make_beat(OP_ENTER_MANUAL, 32'd0, 32'd0, 24'd0, 2'd0), 1'b0, '0});
        script.push_back('{make_beat(OP_FORCE_OPEN, 32'd0, 32'd0, 24'd0, 2'd1), 1'b0, '0});
        // Arm keeps the open batches
        script.push_back('{make_beat(OP_ARM, 32'd0, 32'd0, 24'd0, 2'd0), 1'b0, '0});
        script.push_back('{make_beat(OP_DISARM, 32'd0, 32'd0, 24'd0, 2'd0), 1'b1,
                           make_result(MODE_IDLE, 2'd0, 3'b000, ACT_NONE, 2'd0, 1'b0)});
        foreach (script[k])
            send_beat(script[k].beat, script[k].has_fixed, script[k].fixed);

        // Random phases over several threshold settings
        run_phase(STAGE1_ETA_RST, STAGE2_ETA_RST, STAGE3_ETA_RST, FINAL_TIMEOUT_RST, 300, 1'b0);
        s3 = 16'($urandom_range(1, 3000));
        s2 = s3 + 16'($urandom_range(0, 3000));
        run_phase(s2 + 16'($urandom_range(0, 3000)), s2, s3, 16'($urandom_range(0, 5000)),
                  250, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 250, 1'b1);
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 150, 1'b0);
        run_phase(16'd4000, 16'd2500, 16'd1200, 16'd0, 250, 1'b0);
        run_phase(pick_limit(), pick_limit(), pick_limit(), pick_limit(), 300, 1'b0);

        // Drain and let the pipeline go quiet
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("run covered %0d beats (%0d with effect) over %0d threshold settings",
                 beats_taken, effect_beats, settings_used + 1);
        $display("%0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
